[rtl/core/xte_pkg.sv]
// ----------------------------------------------------------------------------
// xte_pkg: shared types and constants of the XML text extractor
// Entity tables, controller-to-datapath command and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package xte_pkg;

	// entity table: six entities, up to six characters each
	localparam int NUM_ENT = 6;
	localparam int ENT_W   = 6;

	// an '&' with fewer than this many queued bytes (itself included)
	// cannot decode once the document has ended
	localparam logic [2:0] AMP_MIN_SPAN = 3'd5;

	typedef logic [7:0] byte_t;

	localparam byte_t ENT_CHARS [NUM_ENT][ENT_W] = '{
		'{8'h26, 8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00},  // &amp;
		'{8'h26, 8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},  // &lt;
		'{8'h26, 8'h67, 8'h74, 8'h3b, 8'h00, 8'h00},  // &gt;
		'{8'h26, 8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b},  // &quot;
		'{8'h26, 8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b},  // &apos;
		'{8'h26, 8'h6e, 8'h62, 8'h73, 8'h70, 8'h3b}   // &nbsp;
	};

	localparam logic [2:0] ENT_LEN [NUM_ENT] = '{3'd5, 3'd4, 3'd4, 3'd6, 3'd6, 3'd6};

	localparam byte_t ENT_VALUE [NUM_ENT] = '{8'h26, 8'h3c, 8'h3e, 8'h22, 8'h27, 8'h20};

	// controller -> datapath
	typedef struct packed {
		logic load;   // append the accepted byte to the queue
		logic step;   // process the byte at the queue head
		logic flush;  // close the item: release held byte or end marker
	} xte_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic head_ok;     // queue head can be processed now
		logic emits;       // processing the head yields a text byte
		logic hold_valid;  // a text byte is held back
		logic out_free;    // output register can take a beat this cycle
		logic ended;       // current item was the document's last byte
	} xte_stat_t;

endpackage

`default_nettype wire

[rtl/core/xml_text_extractor_unit.sv]
// ----------------------------------------------------------------------------
// xml_text_extractor_unit: XML markup stripper with entity decode
// One document byte in per beat; text bytes out, markup dropped, entities
// decoded, whitespace folded and collapsed.
// ----------------------------------------------------------------------------
//  channel | dir | tdata         | tlast              | tuser
//  s_      | in  | [7:0] in_byte | doc_last           | -
//  m_      | out | [7:0] out_byte| run_last           | [0] byte_valid, [1] doc_end
//
//  Steps: accept a byte, process the queued bytes one head byte per cycle while
//  the output does not stall, see the queue drained or waiting, close the item;
//  a byte held as lookahead stays queued. Stalls: m_tready low with a beat
//  pending holds a step when a second text byte of the item is due and the
//  close when it has a beat to send; no new byte is accepted meanwhile.
//  Reset: arst_n clears markup state, queue count and output valid at once.
// ----------------------------------------------------------------------------
`default_nettype none

module xml_text_extractor_unit
	import xte_pkg::*;
#(
	parameter int PENDING_DEPTH = 6
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire  [7:0] s_tdata,   // [7:0] in_byte
	input  wire        s_tlast,
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast,
	output logic [1:0] m_tuser    // [0] byte_valid, [1] doc_end
);

	xte_cmd_t  cmd;
	xte_stat_t st;

	xte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	xte_dpath #(
		.PENDING_DEPTH (PENDING_DEPTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.in_byte      (s_tdata),
		.in_last      (s_tlast),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.out_byte     (m_tdata),
		.out_bvalid   (m_tuser[0]),
		.out_run_last (m_tlast),
		.out_doc_end  (m_tuser[1])
	);

endmodule

`default_nettype wire

[rtl/core/xte_ctrl.sv]
// ----------------------------------------------------------------------------
// xte_ctrl: sequencer of the XML text extractor
// Accepts one byte, steps the datapath over the queued bytes, then closes
// the item.
// ----------------------------------------------------------------------------
`default_nettype none

module xte_ctrl
	import xte_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  xte_stat_t  st,
	output xte_cmd_t   cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_PROC,
		S_FLUSH
	} state_t;

	state_t state_q;
	logic   final_push;

	assign in_ready   = (state_q == S_IDLE);
	// the close of an item needs the output only if there is something to send
	assign final_push = st.hold_valid | st.ended;

	// command decode
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:  cmd.load  = in_valid;
			S_PROC:  cmd.step  = st.head_ok & ~(st.emits & st.hold_valid & ~st.out_free);
			S_FLUSH: cmd.flush = ~final_push | st.out_free;
			default: cmd = '0;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_PROC;
				end
				S_PROC: begin
					if (!st.head_ok) state_q <= S_FLUSH;
				end
				S_FLUSH: begin
					if (cmd.flush) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/core/xte_dpath.sv]
// ----------------------------------------------------------------------------
// xte_dpath: datapath of the XML text extractor
// Lookahead queue, entity match, markup and space tracking, held byte and
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module xte_dpath
	import xte_pkg::*;
#(
	parameter int PENDING_DEPTH = 6
) (
	input  wire        clk,
	input  wire        arst_n,
	input  xte_cmd_t   cmd,
	output xte_stat_t  st,
	input  wire  [7:0] in_byte,
	input  wire        in_last,
	input  wire        out_ready,
	output logic       out_valid,
	output logic [7:0] out_byte,
	output logic       out_bvalid,
	output logic       out_run_last,
	output logic       out_doc_end
);

	localparam int IW = $clog2(PENDING_DEPTH);
	localparam int CW = $clog2(PENDING_DEPTH + 1);

	localparam byte_t CH_TAB   = 8'h09;
	localparam byte_t CH_LF    = 8'h0a;
	localparam byte_t CH_CR    = 8'h0d;
	localparam byte_t CH_SPACE = 8'h20;
	localparam byte_t CH_LT    = 8'h3c;
	localparam byte_t CH_GT    = 8'h3e;
	localparam byte_t CH_AMP   = 8'h26;

	logic [PENDING_DEPTH-1:0][7:0] q_q;
	logic [CW-1:0]                 cnt_q;
	logic                          inside_q;
	logic                          prev_sp_q;
	logic                          ended_q;
	logic                          hold_valid_q;
	byte_t                         hold_q;
	logic                          out_valid_q;
	byte_t                         out_byte_q;
	logic                          out_bvalid_q;
	logic                          out_run_last_q;
	logic                          out_doc_end_q;

	byte_t         head;
	logic [NUM_ENT-1:0] ent_full;
	logic [NUM_ENT-1:0] ent_part;
	logic          amp_wait;
	logic [2:0]    consume;
	logic          text;
	byte_t         raw_c;
	byte_t         emit_c;
	logic          is_sp;
	logic          emits;
	logic          set_inside;
	logic          clr_inside;
	logic          out_free;
	logic          push_step;
	logic          push_flush;
	byte_t         full_val;
	logic [2:0]    full_len;

	assign head     = q_q[0];
	assign out_free = ~out_valid_q | out_ready;

	// entity match against the queued lookahead
	always_comb begin
		logic same;
		ent_full = '0;
		ent_part = '0;
		for (int e = 0; e < NUM_ENT; e++) begin
			same = 1'b1;
			for (int i = 0; i < ENT_W; i++) begin
				if ((cnt_q > CW'(i)) && (ENT_LEN[e] > 3'(i)) && (q_q[i] != ENT_CHARS[e][i]))
					same = 1'b0;
			end
			ent_full[e] = same & (CW'(ENT_LEN[e]) <= cnt_q);
			ent_part[e] = same & (CW'(ENT_LEN[e]) > cnt_q);
		end
	end

	// the entities are prefix-free, so at most one full match
	always_comb begin
		full_val = CH_AMP;
		full_len = 3'd1;
		for (int e = 0; e < NUM_ENT; e++) begin
			if (ent_full[e]) begin
				full_val = ENT_VALUE[e];
				full_len = ENT_LEN[e];
			end
		end
	end

	// head byte action
	always_comb begin
		amp_wait   = 1'b0;
		consume    = 3'd1;
		text       = 1'b0;
		raw_c      = head;
		set_inside = 1'b0;
		clr_inside = 1'b0;
		if (inside_q) begin
			clr_inside = (head == CH_GT);
		end else if (head == CH_LT) begin
			set_inside = 1'b1;
		end else if (head == CH_AMP) begin
			if (|ent_full) begin
				text = 1'b1;
				if (!(ended_q && (cnt_q < CW'(AMP_MIN_SPAN)))) begin
					raw_c   = full_val;
					consume = full_len;
				end
			end else if (!(|ent_part) || ended_q) begin
				text = 1'b1;
			end else begin
				amp_wait = 1'b1;
			end
		end else begin
			text = 1'b1;
		end
	end

	// whitespace folding and space collapse
	always_comb begin
		emit_c = raw_c;
		if (raw_c == CH_TAB || raw_c == CH_LF || raw_c == CH_CR) emit_c = CH_SPACE;
		is_sp = (emit_c == CH_SPACE);
		emits = text & ~(is_sp & prev_sp_q);
	end

	assign st.head_ok    = (cnt_q != '0) & ~amp_wait;
	assign st.emits      = emits;
	assign st.hold_valid = hold_valid_q;
	assign st.out_free   = out_free;
	assign st.ended      = ended_q;

	assign push_step  = cmd.step & emits & hold_valid_q;
	assign push_flush = cmd.flush & (hold_valid_q | ended_q);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			inside_q     <= 1'b0;
			prev_sp_q    <= 1'b1;
			ended_q      <= 1'b0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (cnt_q < CW'(PENDING_DEPTH)) cnt_q <= cnt_q + 1'b1;
				ended_q <= in_last;
			end
			if (cmd.step) begin
				cnt_q <= cnt_q - CW'(consume);
				if (set_inside) inside_q <= 1'b1;
				if (clr_inside) inside_q <= 1'b0;
				if (emits) begin
					prev_sp_q    <= is_sp;
					hold_valid_q <= 1'b1;
				end
			end
			if (cmd.flush) begin
				hold_valid_q <= 1'b0;
				if (ended_q) begin
					cnt_q     <= '0;
					inside_q  <= 1'b0;
					prev_sp_q <= 1'b1;
					ended_q   <= 1'b0;
				end
			end
			if (push_step || push_flush) out_valid_q <= 1'b1;
			else if (out_ready)          out_valid_q <= 1'b0;
		end
	end

	// payload: queue, held byte, output beat
	always_ff @(posedge clk) begin
		if (cmd.load && (cnt_q < CW'(PENDING_DEPTH))) q_q[cnt_q[IW-1:0]] <= in_byte;
		if (cmd.step) begin
			q_q <= q_q >> {consume, 3'b000};
			if (emits) hold_q <= emit_c;
		end
		if (push_step) begin
			out_byte_q     <= hold_q;
			out_bvalid_q   <= 1'b1;
			out_run_last_q <= 1'b0;
			out_doc_end_q  <= 1'b0;
		end else if (push_flush) begin
			out_byte_q     <= hold_valid_q ? hold_q : 8'h00;
			out_bvalid_q   <= hold_valid_q;
			out_run_last_q <= 1'b1;
			out_doc_end_q  <= ended_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign out_bvalid   = out_bvalid_q;
	assign out_run_last = out_run_last_q;
	assign out_doc_end  = out_doc_end_q;

	// checks
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push_step || push_flush) |-> out_free)
		else $error("output beat overwritten");
	a_step_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (cnt_q != '0) && (CW'(consume) <= cnt_q))
		else $error("step on short queue");
	a_load_clean: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !hold_valid_q && (cnt_q < CW'(PENDING_DEPTH)))
		else $error("load with held byte or full queue");
	a_end_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.flush && ended_q) |-> (cnt_q == '0))
		else $error("document ended with queued bytes");
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> !hold_valid_q)
		else $error("held byte survived item close");

endmodule

`default_nettype wire

[tb/sv/xml_text_extractor_unit_tb.sv]
// ----------------------------------------------------------------------------
// xml_text_extractor_unit_tb: self-checking bench of the XML text extractor
// Feeds byte-wide documents (directed corner cases, then random documents of
// text, tags, entities, broken entities and noise) and compares every output
// beat against an in-bench text predictor. Both stream sides idle at random,
// and the output side holds off once for a long stretch to stall the input.
// ----------------------------------------------------------------------------
`default_nettype none

module xml_text_extractor_unit_tb;

	// character codes
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0a;
	localparam logic [7:0] CH_CR  = 8'h0d;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_AMP = 8'h26;
	localparam logic [7:0] CH_LT  = 8'h3c;
	localparam logic [7:0] CH_GT  = 8'h3e;
	localparam logic [7:0] CH_A   = 8'h61;

	localparam int PEND_DEPTH = 6;   // lookahead queue depth
	localparam int MAX_BEATS  = 8;   // cap on the beats predicted for one input byte
	localparam int AMP_SPAN   = 5;   // queued bytes an '&' needs at document end
	localparam int NUM_ENT    = 6;

	localparam int RAND_PER_PHASE = 135;
	localparam int HOLD_CYCLES    = 400;
	localparam int TAIL_CYCLES    = 40;
	localparam int LIMIT_CYCLES   = 500000;

	// entity spellings, lengths and decoded values
	localparam logic [7:0] ENT_TXT [NUM_ENT][6] = '{
		'{8'h26, 8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00},  // &amp;
		'{8'h26, 8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},  // &lt;
		'{8'h26, 8'h67, 8'h74, 8'h3b, 8'h00, 8'h00},  // &gt;
		'{8'h26, 8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b},  // &quot;
		'{8'h26, 8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b},  // &apos;
		'{8'h26, 8'h6e, 8'h62, 8'h73, 8'h70, 8'h3b}   // &nbsp;
	};
	localparam int ENT_LEN [NUM_ENT] = '{5, 4, 4, 6, 6, 6};
	localparam logic [7:0] ENT_VAL [NUM_ENT] = '{8'h26, 8'h3c, 8'h3e, 8'h22, 8'h27, 8'h20};

	typedef enum int {AMP_WAIT, AMP_DECODE, AMP_LITERAL} amp_verdict_e;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} doc_byte_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       vld;
		logic       rl;
		logic       de;
	} text_beat_t;

	// DUT signals
	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'h00;  // [7:0] in_byte
	logic       s_tlast  = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;           // [7:0] out_byte
	logic       m_tlast;
	logic [1:0] m_tuser;           // [0] byte_valid, [1] doc_end

	// bench state
	doc_byte_t  byte_feed [$];
	text_beat_t text_due [$];
	text_beat_t step_beats [$];
	int         send_idle_pct = 0;
	int         recv_idle_pct = 0;
	int         n_errors      = 0;
	int         hold_left     = 0;
	bit         hold_req      = 1'b0;
	bit         hold_done     = 1'b0;
	logic       in_taken      = 1'b0;

	// predictor state
	bit         in_tag;
	bit         last_space;
	logic [7:0] look [PEND_DEPTH];
	int         look_n;

	xml_text_extractor_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// text predictor
	// ------------------------------------------------------------------
	task automatic clear_text_state();
		in_tag     = 1'b0;
		last_space = 1'b1;
		look_n     = 0;
	endtask

	// whitespace folding and collapsing, then append a text beat
	task automatic put_text(input logic [7:0] c_in);
		logic [7:0] c;
		text_beat_t t;
		c = c_in;
		if (c == CH_TAB || c == CH_LF || c == CH_CR) c = CH_SP;
		if (c == CH_SP) begin
			if (last_space) return;
			last_space = 1'b1;
		end else begin
			last_space = 1'b0;
		end
		if (step_beats.size() >= MAX_BEATS) return;
		t.ch  = c;
		t.vld = 1'b1;
		t.rl  = 1'b0;
		t.de  = 1'b0;
		step_beats = {step_beats, t};
	endtask

	// decide what an '&' at the queue head does now
	function automatic amp_verdict_e amp_verdict(input bit ended, output int which);
		int e;
		int i;
		int k;
		bit same;
		bit possible;
		possible = 1'b0;
		which    = 0;
		for (e = 0; e < NUM_ENT; e++) begin
			k    = (look_n < ENT_LEN[e]) ? look_n : ENT_LEN[e];
			same = 1'b1;
			for (i = 0; i < k; i++)
				if (look[i] != ENT_TXT[e][i]) same = 1'b0;
			if (same) begin
				if (ENT_LEN[e] <= look_n) begin
					which = e;
					return (!ended || look_n >= AMP_SPAN) ? AMP_DECODE : AMP_LITERAL;
				end
				possible = 1'b1;
			end
		end
		if (!possible || ended) return AMP_LITERAL;
		return AMP_WAIT;
	endfunction

	// one accepted input byte -> expected output beats
	task automatic predict_text(input logic [7:0] b, input bit ended);
		logic [7:0]   f;
		int           used;
		int           which;
		int           i;
		bit           stop;
		amp_verdict_e verdict;
		text_beat_t   t;
		step_beats.delete();
		if (look_n < PEND_DEPTH) begin
			look[look_n] = b;
			look_n++;
		end
		stop = 1'b0;
		while (look_n > 0 && !stop) begin
			f    = look[0];
			used = 1;
			if (in_tag) begin
				if (f == CH_GT) in_tag = 1'b0;
			end else if (f == CH_LT) begin
				in_tag = 1'b1;
			end else if (f == CH_AMP) begin
				verdict = amp_verdict(ended, which);
				if (verdict == AMP_WAIT) begin
					stop = 1'b1;
				end else if (verdict == AMP_DECODE) begin
					put_text(ENT_VAL[which]);
					used = ENT_LEN[which];
				end else begin
					put_text(CH_AMP);
				end
			end else begin
				put_text(f);
			end
			if (!stop) begin
				if (used > look_n) used = look_n;
				for (i = 0; i < look_n - used; i++) look[i] = look[i + used];
				look_n -= used;
			end
		end
		// document end: bare marker if nothing came out
		if (ended && step_beats.size() == 0) begin
			t = '0;
			step_beats = {step_beats, t};
		end
		for (i = 0; i < step_beats.size(); i++) begin
			t = step_beats[i];
			if (i == step_beats.size() - 1) begin
				t.rl = 1'b1;
				t.de = ended;
			end
			text_due = {text_due, t};
		end
		if (ended) clear_text_state();
	endtask

	// ------------------------------------------------------------------
	// stimulus builders
	// ------------------------------------------------------------------
	task automatic queue_byte(input logic [7:0] d, input bit last);
		doc_byte_t item;
		item.data = d;
		item.last = last;
		byte_feed = {byte_feed, item};
	endtask

	task automatic queue_text(input string s, input bit closes);
		int i;
		for (i = 0; i < s.len(); i++)
			queue_byte(s[i], closes && (i == s.len() - 1));
	endtask

	// random document built from fragments, last byte flagged
	task automatic add_doc(input int target);
		logic [7:0] doc [$];
		logic [7:0] c;
		int         n;
		int         e;
		int         i;
		int         cut;
		while (doc.size() < target) begin
			case ($urandom_range(0, 9)) inside
				[0:2]: begin
					n = $urandom_range(1, 5);
					repeat (n) begin
						c = CH_A + 8'($urandom_range(0, 25));
						doc = {doc, c};
					end
				end
				3: begin
					n = $urandom_range(1, 3);
					repeat (n) begin
						case ($urandom_range(0, 3))
							0: doc = {doc, CH_SP};
							1: doc = {doc, CH_TAB};
							2: doc = {doc, CH_CR};
							default: doc = {doc, CH_LF};
						endcase
					end
				end
				4: begin
					// tag, sometimes with a nested '<' or an '&', rarely unclosed
					doc = {doc, CH_LT};
					n = $urandom_range(0, 4);
					repeat (n) begin
						case ($urandom_range(0, 5))
							0: doc = {doc, CH_LT};
							1: doc = {doc, CH_AMP};
							default: begin
								c = CH_A + 8'($urandom_range(0, 25));
								doc = {doc, c};
							end
						endcase
					end
					if ($urandom_range(0, 9) != 0) doc = {doc, CH_GT};
				end
				5: begin
					e = $urandom_range(0, NUM_ENT - 1);
					for (i = 0; i < ENT_LEN[e]; i++) doc = {doc, ENT_TXT[e][i]};
				end
				6: begin
					// entity prefix broken by a random letter
					e   = $urandom_range(0, NUM_ENT - 1);
					cut = $urandom_range(1, ENT_LEN[e] - 1);
					for (i = 0; i < cut; i++) doc = {doc, ENT_TXT[e][i]};
					c = CH_A + 8'($urandom_range(0, 25));
					doc = {doc, c};
				end
				7: begin
					c = 8'($urandom_range(0, 255));
					doc = {doc, c};
				end
				8: doc = {doc, CH_GT};
				default: doc = {doc, CH_AMP};
			endcase
		end
		for (i = 0; i < doc.size(); i++)
			queue_byte(doc[i], i == doc.size() - 1);
	endtask

	// ------------------------------------------------------------------
	// input driver: new beat at the falling edge once the last one is taken
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		doc_byte_t item;
		if (arst_n && (!s_tvalid || in_taken)) begin
			if (byte_feed.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				item = byte_feed.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= item.data;
				s_tlast  <= item.last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// output side ready, forced low during the long hold-off
	always @(negedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// long hold-off counter, armed once
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// monitor: predict on input beats, check output beats
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		text_beat_t want;
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) predict_text(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				if (text_due.size() == 0) begin
					$error("unexpected beat: out_byte %02h with nothing expected", m_tdata);
					n_errors++;
				end else begin
					want = text_due.pop_front();
					if (m_tdata !== want.ch) begin
						$error("out_byte mismatch: expected %02h, got %02h", want.ch, m_tdata);
						n_errors++;
					end
					if (m_tuser[0] !== want.vld) begin
						$error("byte_valid mismatch: expected %0b, got %0b", want.vld, m_tuser[0]);
						n_errors++;
					end
					if (m_tlast !== want.rl) begin
						$error("run_last mismatch: expected %0b, got %0b", want.rl, m_tlast);
						n_errors++;
					end
					if (m_tuser[1] !== want.de) begin
						$error("doc_end mismatch: expected %0b, got %0b", want.de, m_tuser[1]);
						n_errors++;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// sequence: reset, three idling phases, drain, verdict
	// ------------------------------------------------------------------
	initial begin
		int ph;
		int start;
		clear_text_state();
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		for (ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 37;
					recv_idle_pct = 84;
					// leading whitespace, folding, stray '>'
					queue_text(" \tA\n>", 1'b1);
					// '<' inside markup, document without text
					queue_text("<p<q>", 1'b1);
					// decoded entity, trailing space kept and collapsed
					queue_text("&lt; \t", 1'b1);
					// entity too close to the document end goes out literally
					queue_text("&gt;", 1'b1);
					// failed lookahead replay, byte extremes
					queue_text("&am", 1'b0);
					queue_byte(8'h00, 1'b0);
					queue_byte(8'hff, 1'b1);
				end
				1: begin
					send_idle_pct = 84;
					recv_idle_pct = 37;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			start = byte_feed.size();
			while (byte_feed.size() - start < RAND_PER_PHASE) begin
				if ($urandom_range(0, 7) == 0)
					add_doc(1);
				else
					add_doc($urandom_range(2, 20));
			end
			if (ph == 2) hold_req = 1'b1;
			while (byte_feed.size() != 0 || s_tvalid) @(posedge clk);
			while (text_due.size() != 0) @(posedge clk);
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (n_errors == 0 && text_due.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// run limit
	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire

[filelist.f]
rtl/core/xte_pkg.sv
rtl/core/xte_ctrl.sv
rtl/core/xte_dpath.sv
rtl/core/xml_text_extractor_unit.sv
tb/sv/xml_text_extractor_unit_tb.sv
